/* hdl/sm3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 package
// Constants and round functions shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	typedef logic [31:0] word_t;

	localparam word_t T_LOW  = 32'h79CC4519;
	localparam word_t T_HIGH = 32'h7A879D8A;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

/* hdl/sm3_hash_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine top
// Byte-serial SM3 with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind 0 carries one message byte,
// kind 1 finishes the message. Output channel (out_valid/out_ready) carries
// eight digest words, word_index 0 first, last high on the eighth.
// A byte that does not complete a block leaves the engine idle and ready.
// The 64th byte of a block starts a compression, the rounds and then a fold,
// with in_ready low; the single round datapath sets the cost of a long
// message, and message words are expanded on the fly in a 16-word window.
// A finish pads by shifting in one byte a cycle, appends the 64-bit length
// and then compresses; a second block is needed when the fill count is 56
// or more at the finish transaction.
// in_ready is low while a block is compressed, padded or emitted.
// A stalled receiver holds the current word; nothing advances until taken.
// Reset loads the initial vector and clears the fill count and bit length;
// after the eighth word the engine returns to the initial vector.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);

	sm3_pkg::state_t state_q;
	sm3_pkg::word_t  cv_q [8];
	sm3_pkg::word_t  r_q  [8];
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [5:0]   cnt_q;
	logic         pad_q;
	logic         mark_q;
	logic         fin_q;
	logic [2:0]   idx_q;

	sm3_pkg::word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2, wnew;
	sm3_pkg::word_t w0, w3, w4, w7, w10, w13;
	logic [7:0] pad_byte;

	assign in_ready = (state_q == sm3_pkg::ST_IDLE);
	assign out_valid = (state_q == sm3_pkg::ST_EMIT);
	assign digest_word = cv_q[idx_q];
	assign word_index = idx_q;
	assign last = (idx_q == 3'd7);

	always_comb begin
		w0 = blk_q[511:480];
		w3 = blk_q[415:384];
		w4 = blk_q[383:352];
		w7 = blk_q[287:256];
		w10 = blk_q[191:160];
		w13 = blk_q[95:64];
		pad_byte = mark_q ? sm3_pkg::PAD_BYTE : 8'h00;
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		tj = sm3_pkg::rotl((cnt_q < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, cnt_q[4:0]);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + tj, 5'd7);
		ss2 = ss1 ^ a12;
		if (cnt_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (w0 ^ w4);
		tt2 = gg + r_q[7] + ss1 + w0;
		wnew = sm3_pkg::perm1(w0 ^ w7 ^ sm3_pkg::rotl(w13, 5'd15))
			^ sm3_pkg::rotl(w3, 5'd7) ^ w10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::ST_IDLE;
			cv_q <= sm3_pkg::IV;
			r_q <= '{default: '0};
			blk_q <= '0;
			fill_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			pad_q <= 1'b0;
			mark_q <= 1'b0;
			fin_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				sm3_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (!kind) begin
							blk_q <= {blk_q[503:0], data_byte};
							len_q <= len_q + 64'd8;
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								r_q <= cv_q;
								cnt_q <= '0;
								state_q <= sm3_pkg::ST_ROUND;
							end
						end else begin
							pad_q <= 1'b1;
							mark_q <= 1'b1;
							fin_q <= (fill_q < 6'd56);
							state_q <= sm3_pkg::ST_PAD;
						end
					end
				end
				sm3_pkg::ST_PAD: begin
					if (fin_q && fill_q == 6'd56) begin
						blk_q <= {blk_q[447:0], len_q};
						fill_q <= '0;
						r_q <= cv_q;
						cnt_q <= '0;
						state_q <= sm3_pkg::ST_ROUND;
					end else begin
						blk_q <= {blk_q[503:0], pad_byte};
						mark_q <= 1'b0;
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							r_q <= cv_q;
							cnt_q <= '0;
							state_q <= sm3_pkg::ST_ROUND;
						end
					end
				end
				sm3_pkg::ST_ROUND: begin
					r_q[3] <= r_q[2];
					r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
					r_q[1] <= r_q[0];
					r_q[0] <= tt1;
					r_q[7] <= r_q[6];
					r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
					r_q[5] <= r_q[4];
					r_q[4] <= sm3_pkg::perm0(tt2);
					blk_q <= {blk_q[479:0], wnew};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= sm3_pkg::ST_FOLD;
				end
				sm3_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++)
						cv_q[i] <= cv_q[i] ^ r_q[i];
					idx_q <= '0;
					if (!pad_q) begin
						state_q <= sm3_pkg::ST_IDLE;
					end else if (fin_q) begin
						state_q <= sm3_pkg::ST_EMIT;
					end else begin
						fin_q <= 1'b1;
						state_q <= sm3_pkg::ST_PAD;
					end
				end
				sm3_pkg::ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							cv_q <= sm3_pkg::IV;
							fill_q <= '0;
							len_q <= '0;
							pad_q <= 1'b0;
							mark_q <= 1'b0;
							fin_q <= 1'b0;
							state_q <= sm3_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= sm3_pkg::ST_IDLE;
			endcase
		end
	end

endmodule
